// File: hw/rtl/iaid_pkg.sv
// Package for the indexed array block: item types, operation codes,
// status codes, sequencer states and the command broadcast to the cells.
// No dependencies.
`timescale 1ns / 1ps

package iaid_pkg;

  typedef enum logic [1:0] {
    F_INSERT = 2'd0,
    F_DELETE = 2'd1,
    F_READ   = 2'd2,
    F_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    M_INDEX  = 2'd0,
    M_BEGIN  = 2'd1,
    M_MIDDLE = 2'd2,
    M_END    = 2'd3
  } pos_mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         position_mode;
    logic [5:0]         index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         length;
  } out_item_t;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins;   // open a slot at the position and write the new word
    logic del;   // close the slot at the position
    logic cap;   // load the word at the position into the tap chain
    logic walk;  // move the tap chain one cell toward cell zero
  } cell_cmd_t;

endpackage

// File: hw/rtl/indexed_array_insert_delete.sv
// Top level of the indexed array: sequencer, entry count and the cell chain.
// Depends on iaid_pkg and iaid_cell.
`timescale 1ns / 1ps
//
//   Channel   Ports                          Direction   Payload
//   input     in_valid, in_stall, in_item    in          func, position_mode, index, value
//   result    out_valid, out_stall, out_item out         status, read_value, length
//
// An insert, an unused operation code and every failed operation give their
// result in the cycle after acceptance. A read or delete at position p
// waits on the tap chain, which carries the selected word one cell per cycle
// down to cell zero. Reset clears the entry count and the sequencer; entries
// are undefined until written. While a result is stalled at the output the
// block accepts no new item, except in the cycle in which the result leaves.

module indexed_array_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iaid_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iaid_pkg::out_item_t  out_item
);
  import iaid_pkg::*;

  // Count width holds DEPTH itself; position width also covers the 6-bit index.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int AW = $clog2(DEPTH);

  seq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic [PW-1:0] count_w;
  logic [PW-1:0] pos;
  logic accept;
  logic out_free;
  logic is_full;
  cell_cmd_t cmd;

  logic signed [31:0] data_q [DEPTH];
  logic signed [31:0] tap_q [DEPTH];

  assign count_w  = PW'(count_r);
  assign is_full  = (count_r == CW'(DEPTH));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Resolve the position. End means append for insert and the last entry
  // otherwise; the empty case is caught before the position is used.
  always_comb begin
    case (in_item.position_mode)
      M_INDEX:  pos = PW'(in_item.index);
      M_BEGIN:  pos = '0;
      M_MIDDLE: pos = count_w >> 1;
      M_END:    pos = (in_item.func == F_INSERT) ? count_w : count_w - PW'(1);
      default:  pos = PW'(in_item.index);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cmd           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.status     = ST_OK;
          out_item_nxt.read_value = '0;
          case (in_item.func)
            F_INSERT: begin
              if (is_full) begin
                out_item_nxt.status = ST_FULL;
              end else if (pos > count_w) begin
                out_item_nxt.status = ST_RANGE;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            F_DELETE, F_READ: begin
              if (count_r == '0) begin
                out_item_nxt.status = ST_EMPTY;
              end else if (pos >= count_w) begin
                out_item_nxt.status = ST_RANGE;
              end else begin
                // The word leaves through the tap chain; the result waits.
                cmd.cap       = 1'b1;
                cmd.del       = (in_item.func == F_DELETE);
                walk_nxt      = pos[AW-1:0];
                out_valid_nxt = 1'b0;
                state_nxt     = S_WALK;
                if (in_item.func == F_DELETE) begin
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            default: begin
            end
          endcase
          out_item_nxt.length = 7'(count_nxt);
        end
      end
      S_WALK: begin
        if (walk_r == '0) begin
          if (out_free) begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.status     = ST_OK;
            out_item_nxt.read_value = tap_q[0];
            out_item_nxt.length     = 7'(count_r);
            state_nxt               = S_IDLE;
          end
        end else begin
          cmd.walk = 1'b1;
          walk_nxt = walk_r - AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The chain: each cell sees its lower neighbor for insert shifts and its
  // upper neighbor for delete shifts and the tap chain.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [31:0] left_w, right_w, rtap_w;
    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = data_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_w = data_q[gi];
      assign rtap_w  = '0;
    end else begin : g_inner_r
      assign right_w = data_q[gi+1];
      assign rtap_w  = tap_q[gi+1];
    end

    iaid_cell #(
      .IDX (gi),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .ins_value  (in_item.value),
      .left_data  (left_w),
      .right_data (right_w),
      .right_tap  (rtap_w),
      .data_q     (data_q[gi]),
      .tap_q      (tap_q[gi])
    );
  end

  // The count never exceeds the array size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above array size");

  // While the tap chain walks, no result is held and no item enters.
  a_walk_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (!out_valid_r && in_stall))
    else $error("walk overlaps a result or an accept");

  // A walk that ends delivers an ok result.
  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && walk_r == '0) |=> (out_valid_r && out_item_r.status == ST_OK))
    else $error("walk finished without ok result");

  // Neither a read nor a delete changes the count across its walk.
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |=> (count_r == $past(count_r)))
    else $error("count changed during walk");

endmodule

// File: hw/rtl/iaid_cell.sv
// One cell of the entry chain: holds one entry and one tap word.
// Depends on iaid_pkg for the cell command struct.
`timescale 1ns / 1ps

module iaid_cell #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  logic                 clk,
  input  iaid_pkg::cell_cmd_t  cmd,
  input  logic [PW-1:0]        pos,
  input  logic signed [31:0]   ins_value,
  input  logic signed [31:0]   left_data,
  input  logic signed [31:0]   right_data,
  input  logic signed [31:0]   right_tap,
  output logic signed [31:0]   data_q,
  output logic signed [31:0]   tap_q
);
  import iaid_pkg::*;

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  logic signed [31:0] data_r, data_nxt;
  logic signed [31:0] tap_r, tap_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (MY_POS == pos) begin
        data_nxt = ins_value;
      end else if (MY_POS > pos) begin
        data_nxt = left_data;
      end
    end else if (cmd.del && (MY_POS >= pos)) begin
      data_nxt = right_data;
    end
  end

  // The tap chain carries a selected word down to cell zero, one cell a cycle.
  always_comb begin
    tap_nxt = tap_r;
    if (cmd.cap && (MY_POS == pos)) begin
      tap_nxt = data_r;
    end else if (cmd.walk) begin
      tap_nxt = right_tap;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data_q = data_r;
  assign tap_q  = tap_r;

endmodule

// File: sim/tb_indexed_array_insert_delete.sv
// Self-checking testbench for indexed_array_insert_delete: a scoreboard class
// tracks the array contents and predicts each result, and plain tasks drive it.
// Depends on iaid_pkg and the RTL of indexed_array_insert_delete.
`timescale 1ns / 1ps

module tb_indexed_array_insert_delete;
  import iaid_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 800;
  // The slowest item is a read or delete at the deepest position, plus the
  // largest sender gap and receiver stall. The limit allows several times
  // that much for every item.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  // Shadow copy of the array. Each accepted item updates it and queues the
  // result that the block must return for that item.
  class array_tracker;
    localparam int DEPTH = 64;

    logic signed [31:0] words [DEPTH];
    int used;
    out_item_t replies_due [$];
    int mismatches;

    function new();
      used = 0;
      mismatches = 0;
    endfunction

    // Resolve the position mode to an array position.
    function int locate(in_item_t it, bit for_insert);
      case (it.position_mode)
        M_BEGIN:  return 0;
        M_MIDDLE: return used / 2;
        M_END:    return for_insert ? used : used - 1;
        default:  return int'(it.index);
      endcase
    endfunction

    function void note_op(in_item_t it);
      out_item_t r;
      int pos;
      int i;
      r.status = ST_OK;
      r.read_value = '0;
      case (it.func)
        F_INSERT: begin
          if (used >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = locate(it, 1'b1);
            if (pos > used) begin
              r.status = ST_RANGE;
            end else begin
              for (i = used; i > pos; i--) words[i] = words[i - 1];
              words[pos] = it.value;
              used++;
            end
          end
        end
        F_DELETE, F_READ: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos = locate(it, 1'b0);
            if (pos >= used) begin
              r.status = ST_RANGE;
            end else begin
              r.read_value = words[pos];
              if (it.func == F_DELETE) begin
                for (i = pos; i + 1 < used; i++) words[i] = words[i + 1];
                used--;
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.length = used[6:0];
      replies_due.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, got.length);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  array_tracker tracker;

  // When set, the matching side runs without any idle cycles. These flags
  // flip now and then so that long back-to-back stretches occur.
  bit in_rush;
  bit out_rush;

  // Random traffic alternates between growing and shrinking the array so
  // that both the full and the empty conditions are reached many times.
  bit growing;

  int cycles;

  indexed_array_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_indexed_array_insert_delete NOT OK");
      $finish;
    end
  end

  // Present one item and hold it until the block accepts it. The task is
  // entered and left at a falling edge; the valid stays high on exit so a
  // following item with no gap goes out back to back.
  task automatic drive_item(in_item_t it);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_op(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] f, logic [1:0] m, logic [5:0] idx,
                         logic [31:0] v);
    in_item_t it;
    it.func = f;
    it.position_mode = m;
    it.index = idx;
    it.value = v;
    drive_item(it);
  endtask

  // Receiver: before each result it holds off for a random number of cycles,
  // then takes the next result and hands it to the scoreboard.
  task automatic collect_results();
    int hold;
    forever begin
      hold = out_rush ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_reply(out_item);
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One random operation. Most positions are legal for the current length so
  // that the array actually fills and drains; the rest are arbitrary.
  task automatic send_random_op();
    in_item_t it;
    int roll;
    int n;
    n = tracker.used;
    if (n >= DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (n == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
    if ($urandom_range(0, 99) == 0) growing = ~growing;

    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      it.func = F_NONE;
    end else if (roll < 13) begin
      it.func = F_READ;
    end else if (growing) begin
      it.func = (roll < 78) ? F_INSERT : F_DELETE;
    end else begin
      it.func = (roll < 35) ? F_INSERT : F_DELETE;
    end

    it.position_mode = 2'($urandom_range(0, 3));
    it.value = pick_value();
    if ($urandom_range(0, 99) < 15) begin
      it.index = 6'($urandom_range(0, 63));
    end else if (it.func == F_INSERT) begin
      it.index = 6'($urandom_range(0, (n < DEPTH) ? n : DEPTH - 1));
    end else begin
      it.index = (n > 0) ? 6'($urandom_range(0, n - 1)) : 6'($urandom_range(0, 63));
    end
    drive_item(it);
  endtask

  initial begin
    tracker = new();
    in_rush = 1'b0;
    out_rush = 1'b0;
    growing = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    fork
      collect_results();
    join_none

    // Directed part. Operations on an empty array must report empty, an
    // insert past the length must report out of range, and an insert into
    // an empty array at the end is a plain append.
    send_op(F_READ,   M_END,    6'd0,  32'd0);
    send_op(F_DELETE, M_INDEX,  6'd0,  32'd0);
    send_op(F_INSERT, M_INDEX,  6'd1,  32'd5);
    send_op(F_NONE,   M_INDEX,  6'd0,  32'd0);
    send_op(F_INSERT, M_END,    6'd0,  32'h7FFF_FFFF);
    send_op(F_INSERT, M_BEGIN,  6'd0,  32'h8000_0000);
    send_op(F_INSERT, M_MIDDLE, 6'd0,  32'hFFFF_FFFF);
    // Explicit index equal to the length appends.
    send_op(F_INSERT, M_INDEX,  6'd3,  32'h0000_0000);
    send_op(F_INSERT, M_INDEX,  6'd63, 32'h1234_5678);
    send_op(F_READ,   M_INDEX,  6'd0,  32'd0);
    send_op(F_READ,   M_INDEX,  6'd3,  32'd0);
    send_op(F_READ,   M_BEGIN,  6'd0,  32'd0);
    send_op(F_READ,   M_MIDDLE, 6'd0,  32'd0);
    send_op(F_READ,   M_END,    6'd0,  32'd0);
    // Reads at or beyond the length are out of range.
    send_op(F_READ,   M_INDEX,  6'd4,  32'd0);
    send_op(F_READ,   M_INDEX,  6'd63, 32'd0);
    send_op(F_DELETE, M_INDEX,  6'd63, 32'd0);
    send_op(F_DELETE, M_MIDDLE, 6'd0,  32'd0);
    send_op(F_DELETE, M_END,    6'd0,  32'd0);
    send_op(F_DELETE, M_BEGIN,  6'd0,  32'd0);
    send_op(F_DELETE, M_INDEX,  6'd0,  32'd0);
    send_op(F_DELETE, M_END,    6'd0,  32'd0);
    // An unused code with every other field at its maximum changes nothing.
    send_op(F_NONE,   M_END,    6'd63, 32'hFFFF_FFFF);

    // Random part.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 50 == 0) begin
        in_rush = ($urandom_range(0, 3) == 0);
        out_rush = ($urandom_range(0, 3) == 0);
      end
      send_random_op();
    end
    in_valid = 1'b0;

    // Every item gives exactly one result; wait for all of them, then wait out
    // the drain period to catch any stray result.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("tb_indexed_array_insert_delete OK");
    end else begin
      $display("tb_indexed_array_insert_delete NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/iaid_pkg.sv
hw/rtl/iaid_cell.sv
hw/rtl/indexed_array_insert_delete.sv
sim/tb_indexed_array_insert_delete.sv
